[rtl/tki_pkg.sv]
package tki_pkg;

  // Fixed field widths
  localparam int VAL_W     = 32;
  localparam int IDX_W     = 16;
  localparam int SLOTNUM_W = 3;
  localparam int KCFG_W    = 4;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  // Defaults for the top level parameters
  localparam int              DEF_MAX_SLOTS  = 8;
  localparam longint unsigned DEF_MAX_LENGTH = 64'd65536;

  // Register map, indexed by paddr[2]
  localparam logic REG_SELECT_SMALLEST = 1'b0;
  localparam logic REG_SLOTS_IN_USE    = 1'b1;

  localparam logic              RST_SELECT_SMALLEST = 1'b0;
  localparam logic [KCFG_W-1:0] RST_SLOTS_IN_USE    = 4'd8;

  // Empty-slot values: most negative in max mode, most positive in min mode
  localparam logic signed [VAL_W-1:0] SENT_MAX_MODE = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] SENT_MIN_MODE = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic              select_smallest;
    logic [KCFG_W-1:0] slots_in_use;
    logic              wr_pulse;
  } cfg_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } store_cmd_t;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] index;
  } store_rsp_t;

endpackage

[rtl/tki_cfg.sv]
module tki_cfg
  import tki_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic              sel_r;
  logic [KCFG_W-1:0] slots_r;
  logic              wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r   <= RST_SELECT_SMALLEST;
      slots_r <= RST_SLOTS_IN_USE;
    end else if (wr) begin
      case (paddr[2])
        REG_SELECT_SMALLEST: sel_r   <= pwdata[0];
        REG_SLOTS_IN_USE:    slots_r <= pwdata[KCFG_W-1:0];
        default:             sel_r   <= sel_r;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr[2])
      REG_SELECT_SMALLEST: prdata = {{(APB_DW-1){1'b0}}, sel_r};
      REG_SLOTS_IN_USE:    prdata = {{(APB_DW-KCFG_W){1'b0}}, slots_r};
      default:             prdata = '0;
    endcase
  end

  assign cfg.select_smallest = sel_r;
  assign cfg.slots_in_use    = slots_r;
  assign cfg.wr_pulse        = wr;

endmodule

[rtl/tki_slot_store.sv]
module tki_slot_store
  import tki_pkg::*;
#(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS,
  parameter int SA_W      = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  store_cmd_t       cmd,
  input  logic [SA_W-1:0]  rd_addr,
  input  logic [SA_W-1:0]  wr_addr,
  input  logic [VAL_W-1:0] wr_value,
  input  logic [IDX_W-1:0] wr_index,
  output store_rsp_t       rsp
);

  logic [VAL_W+IDX_W-1:0] mem [MAX_SLOTS];
  logic [MAX_SLOTS-1:0]   valid_r;
  logic [VAL_W+IDX_W-1:0] rdata_r;
  logic                   hit_r;

  // slot memory, one write port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= {wr_value, wr_index};
    end
  end

  // valid bits: an unwritten slot reads as empty
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      valid_r <= '0;
    end else if (cmd.wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (cmd.rd_en) begin
      hit_r <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign rsp.hit   = hit_r;
  assign rsp.value = rdata_r[VAL_W+IDX_W-1:IDX_W];
  assign rsp.index = rdata_r[IDX_W-1:0];

endmodule

[rtl/tki_ctrl.sv]
module tki_ctrl
  import tki_pkg::*;
#(
  parameter int              MAX_SLOTS  = DEF_MAX_SLOTS,
  parameter longint unsigned MAX_LENGTH = DEF_MAX_LENGTH,
  parameter int              SA_W       = 3
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cfg_t                     cfg,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [VAL_W-1:0]  in_sample_value,
  input  logic                     in_end_of_vector,
  output store_cmd_t               cmd,
  output logic [SA_W-1:0]          rd_addr,
  output logic [SA_W-1:0]          wr_addr,
  output logic [VAL_W-1:0]         wr_value,
  output logic [IDX_W-1:0]         wr_index,
  input  store_rsp_t               rsp,
  output logic                     out_valid,
  output logic [SLOTNUM_W-1:0]     out_slot_number,
  output logic [IDX_W-1:0]         out_element_index,
  output logic                     out_final_result
);

  localparam int CW    = (SA_W > KCFG_W) ? SA_W : KCFG_W;
  localparam int CNT_W = $clog2(MAX_LENGTH);

  typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_WRITE, ST_EMIT, ST_DRAIN} state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           cnt_r;
  logic                    rsp_vld_r;
  logic [CW-1:0]           rsp_slot_r;
  logic signed [VAL_W-1:0] best_val_r;
  logic [SA_W-1:0]         best_slot_r;
  logic signed [VAL_W-1:0] sample_r;
  logic                    last_r;
  logic [IDX_W-1:0]        idx_r;
  logic [CNT_W-1:0]        elem_cnt_r;
  logic                    full_r;

  logic [KCFG_W-1:0]       k_eff;
  logic [CW-1:0]           kx;
  logic signed [VAL_W-1:0] sentinel;
  logic signed [VAL_W-1:0] rv;
  logic                    weaker;
  logic                    replace;
  logic [63:0]             cnt_ext;

  // active slot count, clamped to 1..MAX_SLOTS
  always_comb begin
    if (cfg.slots_in_use == '0) begin
      k_eff = KCFG_W'(1);
    end else if (32'(cfg.slots_in_use) > MAX_SLOTS) begin
      k_eff = KCFG_W'(MAX_SLOTS);
    end else begin
      k_eff = cfg.slots_in_use;
    end
  end
  assign kx = CW'(k_eff);

  assign sentinel = cfg.select_smallest ? SENT_MIN_MODE : SENT_MAX_MODE;
  assign rv       = rsp.hit ? $signed(rsp.value) : sentinel;
  assign weaker   = cfg.select_smallest ? (rv > best_val_r) : (rv < best_val_r);
  assign replace  = cfg.select_smallest ? (sample_r <= best_val_r) : (sample_r >= best_val_r);
  assign cnt_ext  = 64'(elem_cnt_r);

  // store commands
  always_comb begin
    cmd.rd_en = ((state_r == ST_SCAN) || (state_r == ST_EMIT)) && (cnt_r < kx);
    cmd.wr_en = (state_r == ST_WRITE) && replace;
    cmd.clear = (state_r == ST_DRAIN) || cfg.wr_pulse;
  end
  assign rd_addr  = cnt_r[SA_W-1:0];
  assign wr_addr  = best_slot_r;
  assign wr_value = sample_r;
  assign wr_index = idx_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (!full_r)               state_nxt = ST_SCAN;
          else if (in_end_of_vector) state_nxt = ST_EMIT;
        end
      end
      ST_SCAN: begin
        if (rsp_vld_r && (rsp_slot_r == kx - CW'(1))) state_nxt = ST_WRITE;
      end
      ST_WRITE: state_nxt = last_r ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (cnt_r == kx - CW'(1)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cnt_r      <= '0;
      rsp_vld_r  <= 1'b0;
      rsp_slot_r <= '0;
      elem_cnt_r <= '0;
      full_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rsp_vld_r  <= cmd.rd_en;
      rsp_slot_r <= cnt_r;
      if (cmd.rd_en) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (state_r == ST_IDLE || state_r == ST_WRITE) begin
        cnt_r <= '0;
      end
      if (state_r == ST_IDLE && start && !full_r) begin
        elem_cnt_r <= elem_cnt_r + CNT_W'(1);
        if (elem_cnt_r == CNT_W'(MAX_LENGTH - 64'd1)) full_r <= 1'b1;
      end
      // end of vector or register write restarts the count
      if (cmd.clear) begin
        elem_cnt_r <= '0;
        full_r     <= 1'b0;
      end
    end
  end

  // beat capture and running weakest slot
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      sample_r <= in_sample_value;
      last_r   <= in_end_of_vector;
      idx_r    <= cnt_ext[IDX_W-1:0];
    end
    if (state_r == ST_SCAN && rsp_vld_r && ((rsp_slot_r == '0) || weaker)) begin
      best_val_r  <= rv;
      best_slot_r <= rsp_slot_r[SA_W-1:0];
    end
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = rsp_vld_r && ((state_r == ST_EMIT) || (state_r == ST_DRAIN));
  assign out_slot_number   = rsp_slot_r[SLOTNUM_W-1:0];
  assign out_element_index = rsp.hit ? rsp.index : '0;
  assign out_final_result  = (rsp_slot_r == kx - CW'(1));

endmodule

[rtl/streaming_top_k_index_select_top.sv]
// Streaming top-k index selection.
// Elements of a vector arrive one beat at a time on in_sample_value (signed
// Q16.16) with in_end_of_vector on the last one. A beat is taken when start
// is high and busy is low. The block keeps the k largest (or, with
// select_smallest set, the k smallest) elements in a small slot memory and,
// on the last element, emits k result beats in slot order: out_valid is high
// for one cycle per beat, carrying slot number, element index and
// out_final_result on the last beat. The receiver cannot stall; results go
// out on consecutive cycles.
// Per element, busy covers a scan of the slot memory (one read per slot
// through its single read port), then one compare and write-back; the next
// beat is taken only once the block is idle again, so a new element cannot
// go in before the last one is written back. After the last element, all
// active slots are read out in slot order. Once the index range is used up,
// further elements are dropped without a scan.
// Configuration goes through the APB port (select_smallest at 0, slots_in_use
// at 4); any write empties the slots and restarts the vector. Reset restores
// max mode with eight slots, all empty; emptying is by valid bits, at once.
module streaming_top_k_index_select_top
  import tki_pkg::*;
#(
  parameter int              MAX_SLOTS  = DEF_MAX_SLOTS,
  parameter longint unsigned MAX_LENGTH = DEF_MAX_LENGTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_AW-1:0]       paddr,
  input  logic [APB_DW-1:0]       pwdata,
  output logic [APB_DW-1:0]       prdata,
  output logic                    pready,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [VAL_W-1:0] in_sample_value,
  input  logic                    in_end_of_vector,
  output logic                    out_valid,
  output logic [SLOTNUM_W-1:0]    out_slot_number,
  output logic [IDX_W-1:0]        out_element_index,
  output logic                    out_final_result
);

  localparam int SA_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  cfg_t             cfg;
  store_cmd_t       cmd;
  store_rsp_t       rsp;
  logic [SA_W-1:0]  rd_addr;
  logic [SA_W-1:0]  wr_addr;
  logic [VAL_W-1:0] wr_value;
  logic [IDX_W-1:0] wr_index;

  tki_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tki_slot_store #(
    .MAX_SLOTS (MAX_SLOTS),
    .SA_W      (SA_W)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .wr_value (wr_value),
    .wr_index (wr_index),
    .rsp      (rsp)
  );

  tki_ctrl #(
    .MAX_SLOTS  (MAX_SLOTS),
    .MAX_LENGTH (MAX_LENGTH),
    .SA_W       (SA_W)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .start             (start),
    .busy              (busy),
    .in_sample_value   (in_sample_value),
    .in_end_of_vector  (in_end_of_vector),
    .cmd               (cmd),
    .rd_addr           (rd_addr),
    .wr_addr           (wr_addr),
    .wr_value          (wr_value),
    .wr_index          (wr_index),
    .rsp               (rsp),
    .out_valid         (out_valid),
    .out_slot_number   (out_slot_number),
    .out_element_index (out_element_index),
    .out_final_result  (out_final_result)
  );

  // results only come out while the block is busy
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result beat while idle");

  // a run starts at slot zero
  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (out_slot_number == '0))
    else $error("result run does not start at slot zero");

  // a run is contiguous up to its final beat
  a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_result |=> out_valid)
    else $error("gap inside result run");

  // nothing follows the final beat directly
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_final_result |=> !out_valid)
    else $error("beat after final result");

endmodule
